// ----- rtl/buck_voltage_pid_pwm_macros.svh -----
// assertion macros shared by the buck voltage loop rtl
// depends on: a clock named clock and an active high reset named reset in the using module
`ifndef BUCK_VOLTAGE_PID_PWM_MACROS_SVH
`define BUCK_VOLTAGE_PID_PWM_MACROS_SVH

// same-cycle implication, disabled during reset
`define BVPP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define BVPP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bvpp_pkg.sv -----
// types, constants and register codes for the buck voltage pid / pwm block
// no dependencies
package bvpp_pkg;

   // timer and duty constants
   localparam logic [15:0] PWM_PERIOD  = 16'd23039;
   localparam logic [14:0] OFF_Q2_DUTY = 15'd0;
   localparam logic [14:0] DUTY_FULL   = 15'd32767;
   localparam logic [14:0] DEAD_TIME   = 15'd921;
   localparam logic [14:0] CMP_CAP     = 15'd22120;
   localparam logic [12:0] TRIG_CAP    = 13'd7000;

   // register reset values
   localparam logic [12:0] RST_VOLTAGE_TARGET = 13'd0;
   localparam logic [12:0] RST_CAL_GAIN       = 13'd4096;
   localparam logic [12:0] RST_CAL_OFFSET     = 13'd0;
   localparam logic [15:0] RST_GAIN_P         = 16'd20543;
   localparam logic [15:0] RST_GAIN_I         = 16'd32;
   localparam logic [15:0] RST_GAIN_D         = 16'd500;
   localparam logic [19:0] RST_INTEGRAL_LIMIT = 20'd5000;
   localparam logic [14:0] RST_Q1_DUTY_FLOOR  = 15'd0;

   localparam int CSR_DATA_W = 20;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_VOLTAGE_TARGET,
      REG_CAL_GAIN,
      REG_CAL_OFFSET,
      REG_GAIN_P,
      REG_GAIN_I,
      REG_GAIN_D,
      REG_INTEGRAL_LIMIT,
      REG_Q1_DUTY_FLOOR
   } reg_index_type;

   typedef struct packed {
      logic        [12:0] voltage_target;
      logic        [12:0] cal_gain;
      logic signed [12:0] cal_offset;
      logic        [15:0] gain_p;
      logic        [15:0] gain_i;
      logic        [15:0] gain_d;
      logic        [19:0] integral_limit;
      logic        [14:0] q1_duty_floor;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CAL,
      ST_ERR,
      ST_PROP,
      ST_INTEG,
      ST_DER,
      ST_SUM,
      ST_UPD,
      ST_DUTY,
      ST_C1,
      ST_C2,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_CAL,
      MUL_PROP,
      MUL_INTEG,
      MUL_DER,
      MUL_Q1,
      MUL_Q2
   } mul_sel_type;

   localparam int MUL_W  = 18;
   localparam int PROD_W = 2 * MUL_W;

   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      logic        err_en;
      logic        prop_en;
      logic        integ_en;
      logic        sum_en;
      logic        upd_en;
      logic        duty_en;
      logic        c1_en;
      logic        out_load;
   } dp_cmd_type;

endpackage

// ----- rtl/bvpp_csr.sv -----
// configuration registers of the buck voltage loop
// depends on: bvpp_pkg
module bvpp_csr import bvpp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (reg_index_type'(csr_index))
            REG_VOLTAGE_TARGET: cfg_in.voltage_target = csr_wdata[12:0];
            REG_CAL_GAIN:       cfg_in.cal_gain       = csr_wdata[12:0];
            REG_CAL_OFFSET:     cfg_in.cal_offset     = csr_wdata[12:0];
            REG_GAIN_P:         cfg_in.gain_p         = csr_wdata[15:0];
            REG_GAIN_I:         cfg_in.gain_i         = csr_wdata[15:0];
            REG_GAIN_D:         cfg_in.gain_d         = csr_wdata[15:0];
            REG_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_wdata[19:0];
            REG_Q1_DUTY_FLOOR:  cfg_in.q1_duty_floor  = csr_wdata[14:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.voltage_target <= RST_VOLTAGE_TARGET;
         cfg_ff.cal_gain       <= RST_CAL_GAIN;
         cfg_ff.cal_offset     <= RST_CAL_OFFSET;
         cfg_ff.gain_p         <= RST_GAIN_P;
         cfg_ff.gain_i         <= RST_GAIN_I;
         cfg_ff.gain_d         <= RST_GAIN_D;
         cfg_ff.integral_limit <= RST_INTEGRAL_LIMIT;
         cfg_ff.q1_duty_floor  <= RST_Q1_DUTY_FLOOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/bvpp_mul.sv -----
// shared signed 18x18 multiplier with registered product
// depends on: bvpp_pkg
module bvpp_mul import bvpp_pkg::*; (
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/bvpp_dp.sv -----
// datapath of the buck voltage loop: calibration, incremental pid, duties, compare points
// depends on: bvpp_pkg, bvpp_mul
module bvpp_dp import bvpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   input  cfg_type     cfg,
   input  logic [11:0] req_adc_sample,
   input  logic [14:0] req_q1_duty_limit,
   input  logic [14:0] req_q2_duty_limit,
   input  logic        req_pwm_enable,
   input  logic        req_clear_loop,
   output logic [14:0] rsp_q1_duty,
   output logic [14:0] rsp_q1_fall_point,
   output logic [14:0] rsp_q2_rise_point,
   output logic [14:0] rsp_q2_fall_point,
   output logic [12:0] rsp_adc_trigger_point
);

   // captured beat
   logic [11:0] sample_ff;
   logic [14:0] q1_lim_ff;
   logic [14:0] q2_lim_ff;
   logic        enable_ff;

   // loop state
   logic signed [14:0] prev_error_ff;
   logic signed [14:0] prev_prev_error_ff;
   logic signed [20:0] integral_acc_ff;
   logic signed [31:0] loop_output_ff;

   // working registers
   logic signed [14:0] err_ff, err_in;
   logic signed [31:0] prop_ff;
   logic signed [20:0] integ_ff, integ_in;
   logic signed [34:0] sum_ff, sum_in;
   logic signed [31:0] u_in;
   logic [14:0] q1_ff, q1_in;
   logic [14:0] q2_ff, q2_in;
   logic [14:0] c1_ff, c1_in;

   // result registers
   logic [14:0] q1_duty_ff;
   logic [14:0] q1_fall_ff;
   logic [14:0] q2_rise_ff, q2_rise_in;
   logic [14:0] q2_fall_ff, q2_fall_in;
   logic [12:0] trig_ff, trig_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;

   logic signed [15:0] diff;
   logic signed [16:0] ddiff;

   bvpp_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // first and second error differences
   assign diff  = {err_ff[14], err_ff} - {prev_error_ff[14], prev_error_ff};
   assign ddiff = {{2{err_ff[14]}}, err_ff} - {prev_error_ff[14], prev_error_ff, 1'b0}
                + {{2{prev_prev_error_ff[14]}}, prev_prev_error_ff};

   always_comb begin
      case (cmd.mul_sel)
         MUL_CAL: begin
            mul_a = {6'd0, sample_ff};
            mul_b = {5'd0, cfg.cal_gain};
         end
         MUL_PROP: begin
            mul_a = {{2{diff[15]}}, diff};
            mul_b = {2'd0, cfg.gain_p};
         end
         MUL_INTEG: begin
            mul_a = {{3{err_ff[14]}}, err_ff};
            mul_b = {2'd0, cfg.gain_i};
         end
         MUL_DER: begin
            mul_a = {ddiff[16], ddiff};
            mul_b = {2'd0, cfg.gain_d};
         end
         MUL_Q1: begin
            mul_a = {3'd0, q1_ff};
            mul_b = {2'd0, PWM_PERIOD};
         end
         MUL_Q2: begin
            mul_a = {3'd0, q2_ff};
            mul_b = {2'd0, PWM_PERIOD};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // calibrated sample and error
   always_comb begin
      logic signed [15:0] corrected;
      logic signed [15:0] err_wide;
      corrected = {3'd0, prod[24:12]} + {{3{cfg.cal_offset[12]}}, cfg.cal_offset};
      err_wide  = {3'd0, cfg.voltage_target} - corrected;
      err_in    = err_wide[14:0];
   end

   // integral with symmetric clamp
   always_comb begin
      logic signed [31:0] raw;
      logic signed [31:0] lim;
      logic signed [31:0] neg_lim;
      raw     = {{11{integral_acc_ff[20]}}, integral_acc_ff} + prod[31:0];
      lim     = {12'd0, cfg.integral_limit};
      neg_lim = -lim;
      if (raw > lim) begin
         integ_in = lim[20:0];
      end else if (raw < neg_lim) begin
         integ_in = neg_lim[20:0];
      end else begin
         integ_in = raw[20:0];
      end
   end

   assign sum_in = {{3{prop_ff[31]}}, prop_ff} + {{14{integ_ff[20]}}, integ_ff} + prod[34:0];

   // output accumulator: floor shift, 32-bit saturation, upper clamp
   always_comb begin
      logic signed [26:0] delta;
      logic signed [32:0] acc;
      logic signed [31:0] sat;
      logic signed [31:0] lim;
      delta = sum_ff[34:8];
      acc   = {loop_output_ff[31], loop_output_ff} + {{6{delta[26]}}, delta};
      if (acc[32] != acc[31]) begin
         sat = acc[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat = acc[31:0];
      end
      lim  = {17'd0, q1_lim_ff};
      u_in = (sat > lim) ? lim : sat;
   end

   // duties
   always_comb begin
      logic signed [31:0] lim;
      logic signed [31:0] lo;
      logic [14:0] q2_raw;
      lim = {17'd0, q1_lim_ff};
      lo  = {17'd0, cfg.q1_duty_floor};
      if (loop_output_ff > lim) begin
         q1_in = q1_lim_ff;
      end else if (loop_output_ff < lo) begin
         q1_in = cfg.q1_duty_floor;
      end else begin
         q1_in = loop_output_ff[14:0];
      end
      q2_raw = DUTY_FULL - q1_in;
      q2_in  = (q2_raw > q2_lim_ff) ? q2_lim_ff : q2_raw;
      if (!enable_ff) begin
         q1_in = cfg.q1_duty_floor;
         q2_in = OFF_Q2_DUTY;
      end
   end

   // q1 fall point
   always_comb begin
      logic [16:0] c1_wide;
      c1_wide = prod[31:15];
      c1_in   = (c1_wide > {2'd0, DUTY_FULL}) ? DUTY_FULL : c1_wide[14:0];
   end

   // q2 edges and adc trigger
   always_comb begin
      logic [15:0] c2_wide;
      logic [17:0] c3_wide;
      logic [13:0] c4_wide;
      c2_wide    = {1'b0, c1_ff} + {1'b0, DEAD_TIME};
      c3_wide    = {2'd0, c2_wide} + {1'b0, prod[31:15]};
      c4_wide    = c1_ff[14:1];
      q2_rise_in = (c2_wide > {1'b0, CMP_CAP}) ? CMP_CAP : c2_wide[14:0];
      q2_fall_in = (c3_wide > {3'd0, CMP_CAP}) ? CMP_CAP : c3_wide[14:0];
      trig_in    = (c4_wide > {1'b0, TRIG_CAP}) ? TRIG_CAP : c4_wide[12:0];
   end

   // loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff      <= '0;
         prev_prev_error_ff <= '0;
         integral_acc_ff    <= '0;
         loop_output_ff     <= '0;
      end else if (cmd.load && req_clear_loop) begin
         prev_error_ff      <= '0;
         prev_prev_error_ff <= '0;
         integral_acc_ff    <= '0;
         loop_output_ff     <= '0;
      end else if (cmd.upd_en) begin
         prev_prev_error_ff <= prev_error_ff;
         prev_error_ff      <= err_ff;
         integral_acc_ff    <= integ_ff;
         loop_output_ff     <= u_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_adc_sample;
         q1_lim_ff <= req_q1_duty_limit;
         q2_lim_ff <= req_q2_duty_limit;
         enable_ff <= req_pwm_enable;
      end
      if (cmd.err_en) begin
         err_ff <= err_in;
      end
      if (cmd.prop_en) begin
         prop_ff <= prod[31:0];
      end
      if (cmd.integ_en) begin
         integ_ff <= integ_in;
      end
      if (cmd.sum_en) begin
         sum_ff <= sum_in;
      end
      if (cmd.duty_en) begin
         q1_ff <= q1_in;
         q2_ff <= q2_in;
      end
      if (cmd.c1_en) begin
         c1_ff <= c1_in;
      end
      if (cmd.out_load) begin
         q1_duty_ff <= q1_ff;
         q1_fall_ff <= c1_ff;
         q2_rise_ff <= q2_rise_in;
         q2_fall_ff <= q2_fall_in;
         trig_ff    <= trig_in;
      end
   end

   assign rsp_q1_duty           = q1_duty_ff;
   assign rsp_q1_fall_point     = q1_fall_ff;
   assign rsp_q2_rise_point     = q2_rise_ff;
   assign rsp_q2_fall_point     = q2_fall_ff;
   assign rsp_adc_trigger_point = trig_ff;

endmodule

// ----- rtl/bvpp_ctrl.sv -----
// sequencer of the buck voltage loop: steps the datapath and owns both handshakes
// depends on: bvpp_pkg, buck_voltage_pid_pwm_macros.svh
`include "buck_voltage_pid_pwm_macros.svh"

module bvpp_ctrl import bvpp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = MUL_CAL;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = accept;
            if (accept) begin
               state_in = ST_CAL;
            end
         end
         ST_CAL: begin
            cmd.mul_sel = MUL_CAL;
            state_in    = ST_ERR;
         end
         ST_ERR: begin
            cmd.err_en = 1'b1;
            state_in   = ST_PROP;
         end
         ST_PROP: begin
            cmd.mul_sel = MUL_PROP;
            state_in    = ST_INTEG;
         end
         ST_INTEG: begin
            cmd.prop_en = 1'b1;
            cmd.mul_sel = MUL_INTEG;
            state_in    = ST_DER;
         end
         ST_DER: begin
            cmd.integ_en = 1'b1;
            cmd.mul_sel  = MUL_DER;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_UPD;
         end
         ST_UPD: begin
            cmd.upd_en = 1'b1;
            state_in   = ST_DUTY;
         end
         ST_DUTY: begin
            cmd.duty_en = 1'b1;
            state_in    = ST_C1;
         end
         ST_C1: begin
            cmd.mul_sel = MUL_Q1;
            state_in    = ST_C2;
         end
         ST_C2: begin
            cmd.c1_en   = 1'b1;
            cmd.mul_sel = MUL_Q2;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            cmd.mul_sel  = MUL_Q2;
            cmd.out_load = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `BVPP_ASSERT_NXT(a_accept_starts, accept, state_ff == ST_CAL, "accepted beat did not start")
   `BVPP_ASSERT_IMP(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT, "result without finish")
   `BVPP_ASSERT_NXT(a_out_waits, (state_ff == ST_OUT) && rsp_valid_ff && rsp_stall, (state_ff == ST_OUT) && rsp_valid_ff, "result dropped while blocked")
   `BVPP_ASSERT_NXT(a_out_delivers, (state_ff == ST_OUT) && !rsp_valid_ff, rsp_valid_ff && (state_ff == ST_IDLE), "free result slot not filled")

endmodule

// ----- rtl/buck_voltage_pid_pwm.sv -----
// top level of the buck converter output-voltage loop with pwm compare points
// depends on: bvpp_pkg, bvpp_csr, bvpp_ctrl, bvpp_dp
//
// One beat in per switching period: a raw output-voltage adc sample plus the soft-start duty
// limits and the enable / clear flags. The sample is calibrated (sample*gain>>12 + offset),
// the error against the target feeds an incremental pid (p on the error difference, clamped
// integral, d on the second difference), and the accumulated loop output sets the q1 duty,
// the complementary q2 duty and four timer compare points (q1 fall, q2 rise and fall with
// 921 ticks of dead time, adc trigger at the q1 center). One result beat comes out per input
// beat. Each beat passes through eleven sequencer steps around the single shared 18x18
// multiplier, which runs six times per beat (calibration, p, i, d and both timer scalings),
// before its result reaches the result register; a new beat is accepted the cycle after the
// previous one has been moved into the result register, so the block takes no new beat
// while one is in flight, and that move waits while the consumer stalls. The user must write
// configuration registers through the csr port only while the block is idle; the block does
// not enforce this. A clear_loop beat zeroes the loop state before its own step.

module buck_voltage_pid_pwm import bvpp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // configuration write port
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // sample beat in
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [11:0]           req_adc_sample,
   input  logic [14:0]           req_q1_duty_limit,
   input  logic [14:0]           req_q2_duty_limit,
   input  logic                  req_pwm_enable,
   input  logic                  req_clear_loop,
   // duty and compare beat out
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [14:0]           rsp_q1_duty,
   output logic [14:0]           rsp_q1_fall_point,
   output logic [14:0]           rsp_q2_rise_point,
   output logic [14:0]           rsp_q2_fall_point,
   output logic [12:0]           rsp_adc_trigger_point
);

   cfg_type    cfg;
   dp_cmd_type cmd;

   // register file, reset to the default tuning
   bvpp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: one step of the datapath per state, result register handshake
   bvpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // arithmetic, loop state and result register
   bvpp_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .cfg                   (cfg),
      .req_adc_sample        (req_adc_sample),
      .req_q1_duty_limit     (req_q1_duty_limit),
      .req_q2_duty_limit     (req_q2_duty_limit),
      .req_pwm_enable        (req_pwm_enable),
      .req_clear_loop        (req_clear_loop),
      .rsp_q1_duty           (rsp_q1_duty),
      .rsp_q1_fall_point     (rsp_q1_fall_point),
      .rsp_q2_rise_point     (rsp_q2_rise_point),
      .rsp_q2_fall_point     (rsp_q2_fall_point),
      .rsp_adc_trigger_point (rsp_adc_trigger_point)
   );

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for buck_voltage_pid_pwm: sample beats in, duty and compare beats out
// depends on: bvpp_pkg (register codes, config struct, timer constants) and the rtl top level
`timescale 1ns / 100ps

module testbench import bvpp_pkg::*; ();

   localparam int     CYCLE_LIMIT    = 600000;   // watchdog bound on the whole run
   localparam int     RESULT_LATENCY = 11;       // extra wait after each drain
   localparam int     RANDOM_PER_CFG = 138;
   localparam longint S32_MAX        = 64'sd2147483647;
   localparam longint S32_MIN        = -64'sd2147483648;

   // one input beat and one result beat, at the port widths
   typedef struct packed {
      logic [11:0] adc_sample;
      logic [14:0] q1_duty_limit;
      logic [14:0] q2_duty_limit;
      logic        pwm_enable;
      logic        clear_loop;
   } sample_beat_type;

   typedef struct packed {
      logic [14:0] q1_duty;
      logic [14:0] q1_fall_point;
      logic [14:0] q2_rise_point;
      logic [14:0] q2_fall_point;
      logic [12:0] adc_trigger_point;
   } duty_beat_type;

   // loop model plus the queue of duty beats still owed by the block
   class duty_scoreboard_type;
      cfg_type       regs;
      int            prev_err;
      int            prev_prev_err;
      int            integ_acc;
      int            loop_out;
      duty_beat_type due[$];
      int unsigned   errors;

      function new();
         regs.voltage_target = RST_VOLTAGE_TARGET;
         regs.cal_gain       = RST_CAL_GAIN;
         regs.cal_offset     = RST_CAL_OFFSET;
         regs.gain_p         = RST_GAIN_P;
         regs.gain_i         = RST_GAIN_I;
         regs.gain_d         = RST_GAIN_D;
         regs.integral_limit = RST_INTEGRAL_LIMIT;
         regs.q1_duty_floor  = RST_Q1_DUTY_FLOOR;
         errors = 0;
         clear_loop_state();
      endfunction

      function void clear_loop_state();
         prev_err      = 0;
         prev_prev_err = 0;
         integ_acc     = 0;
         loop_out      = 0;
      endfunction

      function void write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_VOLTAGE_TARGET: regs.voltage_target = val[12:0];
            REG_CAL_GAIN:       regs.cal_gain       = val[12:0];
            REG_CAL_OFFSET:     regs.cal_offset     = val[12:0];
            REG_GAIN_P:         regs.gain_p         = val[15:0];
            REG_GAIN_I:         regs.gain_i         = val[15:0];
            REG_GAIN_D:         regs.gain_d         = val[15:0];
            REG_INTEGRAL_LIMIT: regs.integral_limit = val[19:0];
            REG_Q1_DUTY_FLOOR:  regs.q1_duty_floor  = val[14:0];
            default: ;
         endcase
      endfunction

      function duty_beat_type predict_duties(sample_beat_type s);
         duty_beat_type d;
         longint corr, err, prop, integ, der, delta, u, lim;
         longint q1, q2, q1_lim, q2_lim, min_q1, c1, c2, c3, c4;
         q1_lim = longint'(s.q1_duty_limit);
         q2_lim = longint'(s.q2_duty_limit);
         min_q1 = longint'(regs.q1_duty_floor);
         if (s.clear_loop) clear_loop_state();
         // calibration, then incremental pid on the error
         corr = ((longint'(s.adc_sample) * longint'(regs.cal_gain)) >>> 12)
              + longint'($signed(regs.cal_offset));
         err  = longint'(regs.voltage_target) - corr;
         prop = (err - longint'(prev_err)) * longint'(regs.gain_p);
         integ = longint'(integ_acc) + err * longint'(regs.gain_i);
         lim = longint'(regs.integral_limit);
         if (integ > lim) integ = lim;
         else if (integ < -lim) integ = -lim;
         der = (err - 2 * longint'(prev_err) + longint'(prev_prev_err))
             * longint'(regs.gain_d);
         delta = (prop + integ + der) >>> 8;
         u = longint'(loop_out) + delta;
         if (u > S32_MAX) u = S32_MAX;
         if (u < S32_MIN) u = S32_MIN;
         if (u > q1_lim) u = q1_lim;
         prev_prev_err = prev_err;
         prev_err      = int'(err);
         integ_acc     = int'(integ);
         loop_out      = int'(u);
         // duties: the limit is tested before the minimum
         q1 = u;
         if (q1 > q1_lim) q1 = q1_lim;
         else if (q1 < min_q1) q1 = min_q1;
         q2 = longint'(DUTY_FULL) - q1;
         if (q2 > q2_lim) q2 = q2_lim;
         if (!s.pwm_enable) begin
            q1 = min_q1;
            q2 = longint'(OFF_Q2_DUTY);
         end
         // compare points; q2 fall builds on the uncapped rise point
         c1 = (q1 * longint'(PWM_PERIOD)) >>> 15;
         if (c1 > longint'(DUTY_FULL)) c1 = longint'(DUTY_FULL);
         c2 = c1 + longint'(DEAD_TIME);
         c3 = c2 + ((q2 * longint'(PWM_PERIOD)) >>> 15);
         c4 = c1 >>> 1;
         if (c2 > longint'(CMP_CAP)) c2 = longint'(CMP_CAP);
         if (c3 > longint'(CMP_CAP)) c3 = longint'(CMP_CAP);
         if (c4 > longint'(TRIG_CAP)) c4 = longint'(TRIG_CAP);
         d.q1_duty           = q1[14:0];
         d.q1_fall_point     = c1[14:0];
         d.q2_rise_point     = c2[14:0];
         d.q2_fall_point     = c3[14:0];
         d.adc_trigger_point = c4[12:0];
         return d;
      endfunction

      function void note_sample(sample_beat_type s);
         due.push_back(predict_duties(s));
      endfunction

      task report(string what);
         $display("%0t ns  mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_field(string name, int unsigned got, int unsigned want);
         if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
      endtask

      task check_duty(duty_beat_type got);
         duty_beat_type want;
         if (due.size() == 0) begin
            report("duty beat with nothing pending");
            return;
         end
         want = due.pop_front();
         check_field("q1_duty", got.q1_duty, want.q1_duty);
         check_field("q1_fall_point", got.q1_fall_point, want.q1_fall_point);
         check_field("q2_rise_point", got.q2_rise_point, want.q2_rise_point);
         check_field("q2_fall_point", got.q2_fall_point, want.q2_fall_point);
         check_field("adc_trigger_point", got.adc_trigger_point, want.adc_trigger_point);
      endtask
   endclass

   // ports, all known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [11:0]           req_adc_sample = '0;
   logic [14:0]           req_q1_duty_limit = '0;
   logic [14:0]           req_q2_duty_limit = '0;
   logic                  req_pwm_enable = 1'b0;
   logic                  req_clear_loop = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [14:0]           rsp_q1_duty;
   logic [14:0]           rsp_q1_fall_point;
   logic [14:0]           rsp_q2_rise_point;
   logic [14:0]           rsp_q2_fall_point;
   logic [12:0]           rsp_adc_trigger_point;

   duty_scoreboard_type duty_sb = new();
   duty_beat_type       seen_duty;
   int unsigned         cycle_count = 0;
   int                  burst_left = 0;
   // receiver stall pattern state
   int                  stall_mode = 0;
   int                  mode_left = 0;
   int                  stall_run = 0;

   buck_voltage_pid_pwm u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_adc_sample        (req_adc_sample),
      .req_q1_duty_limit     (req_q1_duty_limit),
      .req_q2_duty_limit     (req_q2_duty_limit),
      .req_pwm_enable        (req_pwm_enable),
      .req_clear_loop        (req_clear_loop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_q1_duty           (rsp_q1_duty),
      .rsp_q1_fall_point     (rsp_q1_fall_point),
      .rsp_q2_rise_point     (rsp_q2_rise_point),
      .rsp_q2_fall_point     (rsp_q2_fall_point),
      .rsp_adc_trigger_point (rsp_adc_trigger_point)
   );

   always #6 clock = ~clock;

   // watchdog: a hung handshake or a lost beat ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // receiver: check every accepted duty beat, then pick the next stall value.
   // modes: no stall at all, scattered random stalls, long stall runs
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_duty.q1_duty           = rsp_q1_duty;
         seen_duty.q1_fall_point     = rsp_q1_fall_point;
         seen_duty.q2_rise_point     = rsp_q2_rise_point;
         seen_duty.q2_fall_point     = rsp_q2_fall_point;
         seen_duty.adc_trigger_point = rsp_adc_trigger_point;
         duty_sb.check_duty(seen_duty);
      end
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         mode_left  <= $urandom_range(20, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: begin
            if (stall_run != 0) begin
               rsp_stall <= 1'b1;
               stall_run <= stall_run - 1;
            end else begin
               rsp_stall <= 1'b0;
               if ($urandom_range(0, 7) == 0) stall_run <= $urandom_range(5, 30);
            end
         end
      endcase
   end

   function automatic sample_beat_type sample_of(int adc, int q1_lim, int q2_lim, bit en,
                                                 bit clr);
      sample_beat_type b;
      b.adc_sample    = 12'(adc);
      b.q1_duty_limit = 15'(q1_lim);
      b.q2_duty_limit = 15'(q2_lim);
      b.pwm_enable    = en;
      b.clear_loop    = clr;
      return b;
   endfunction

   function automatic cfg_type cfg_of(int target, int gain, int offset, int gp, int gi, int gd,
                                      int lim, int min_q1);
      cfg_type c;
      c.voltage_target = 13'(target);
      c.cal_gain       = 13'(gain);
      c.cal_offset     = 13'(offset);
      c.gain_p         = 16'(gp);
      c.gain_i         = 16'(gi);
      c.gain_d         = 16'(gd);
      c.integral_limit = 20'(lim);
      c.q1_duty_floor  = 15'(min_q1);
      return c;
   endfunction

   // either a plausible converter setup or raw bits in every register
   function automatic cfg_type random_cfg(bit wild);
      if (wild)
         return cfg_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
      return cfg_of($urandom_range(500, 4000), $urandom_range(3500, 4700),
                    int'($urandom_range(0, 400)) - 200, $urandom_range(0, 40000),
                    $urandom_range(0, 3000), $urandom_range(0, 5000),
                    $urandom_range(0, 200000),
                    ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 3000));
   endfunction

   // duty limit with a fair share of both extremes
   function automatic int pick_limit();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 32767;
         default: return $urandom_range(0, 32767);
      endcase
   endfunction

   // one register write, accepted at the next rising edge
   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      duty_sb.write_reg(idx, val);
   endtask

   task automatic set_config(cfg_type c);
      csr_write(REG_VOLTAGE_TARGET, CSR_DATA_W'(c.voltage_target));
      csr_write(REG_CAL_GAIN, CSR_DATA_W'(c.cal_gain));
      csr_write(REG_CAL_OFFSET, {7'd0, c.cal_offset});
      csr_write(REG_GAIN_P, CSR_DATA_W'(c.gain_p));
      csr_write(REG_GAIN_I, CSR_DATA_W'(c.gain_i));
      csr_write(REG_GAIN_D, CSR_DATA_W'(c.gain_d));
      csr_write(REG_INTEGRAL_LIMIT, CSR_DATA_W'(c.integral_limit));
      csr_write(REG_Q1_DUTY_FLOOR, CSR_DATA_W'(c.q1_duty_floor));
      csr_wr_en <= 1'b0;
   endtask

   // sender pause: hold off until every owed duty beat has come back
   task automatic drain(int extra);
      req_valid <= 1'b0;
      while (duty_sb.due.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // send one sample beat; bursts of random length with random gaps between them
   task automatic drive(sample_beat_type b);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 25)) @(posedge clock);
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_adc_sample    <= b.adc_sample;
      req_q1_duty_limit <= b.q1_duty_limit;
      req_q2_duty_limit <= b.q2_duty_limit;
      req_pwm_enable    <= b.pwm_enable;
      req_clear_loop    <= b.clear_loop;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      duty_sb.note_sample(b);
   endtask

   // mostly soft-start runs: clear, ramp the q1 limit, samples wandering around a
   // set point with occasional load steps; the rest is raw noise on every field
   task automatic random_samples(int n);
      int left;
      int len;
      int centre;
      int ceiling;
      int ramp;
      int q1_lim;
      left = n;
      while (left > 0) begin
         if ($urandom_range(0, 9) < 7) begin
            len = $urandom_range(10, 60);
            if (len > left) len = left;
            centre  = $urandom_range(200, 3900);
            ceiling = $urandom_range(1000, 32767);
            ramp    = $urandom_range(100, 3000);
            q1_lim  = 0;
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 15) == 0) centre = $urandom_range(200, 3900);
               q1_lim = q1_lim + ramp;
               if (q1_lim > ceiling) q1_lim = ceiling;
               drive(sample_of(centre + int'($urandom_range(0, 120)) - 60, q1_lim,
                               ceiling, $urandom_range(0, 31) != 0, k == 0));
            end
            left = left - len;
         end else begin
            drive(sample_of($urandom, pick_limit(), pick_limit(),
                            $urandom_range(0, 7) != 0, $urandom_range(0, 15) == 0));
            left--;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset register values: extremes of the sample and of both limits,
      // zero limits, pwm off, clear on an off beat
      drive(sample_of(0, 32767, 32767, 1, 1));
      drive(sample_of(4095, 32767, 32767, 1, 0));
      drive(sample_of(4095, 32767, 32767, 1, 0));
      drive(sample_of(0, 32767, 32767, 1, 0));
      drive(sample_of(0, 0, 32767, 1, 0));
      drive(sample_of(2000, 32767, 0, 1, 0));
      drive(sample_of(2000, 16384, 16384, 0, 0));
      drive(sample_of(4095, 32767, 32767, 0, 1));
      drive(sample_of(1, 32767, 32767, 1, 0));
      drive(sample_of(0, 32767, 32767, 1, 0));
      drive(sample_of(0, 32767, 32767, 1, 0));
      drive(sample_of(2048, 32767, 32767, 1, 1));

      // minimum duty above the soft-start limit: the limit must win
      drain(RESULT_LATENCY);
      set_config(cfg_of(3000, 4096, 0, RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, 5000, 20000));
      drive(sample_of(1000, 10000, 32767, 1, 1));
      drive(sample_of(1000, 30000, 32767, 1, 0));
      drive(sample_of(1000, 32767, 5000, 1, 0));
      drive(sample_of(1000, 10000, 32767, 0, 0));
      drive(sample_of(4095, 32767, 32767, 1, 0));
      drive(sample_of(0, 32767, 32767, 1, 0));

      // every register at its top (offset and minimum duty at their bottom): the loop runs into
      // the duty limit and every compare cap; alternating samples swing p and d
      drain(RESULT_LATENCY);
      set_config(cfg_of(8191, 8191, -4096, 65535, 65535, 65535, 1048575, 0));
      drive(sample_of(0, 32767, 32767, 1, 1));
      drive(sample_of(4095, 32767, 32767, 1, 0));
      drive(sample_of(0, 32767, 32767, 1, 0));
      drive(sample_of(4095, 0, 32767, 1, 0));
      drive(sample_of(0, 32767, 32767, 1, 0));
      drive(sample_of(4095, 32767, 32767, 1, 0));
      random_samples(RANDOM_PER_CFG);

      // registers at the bottom, offset and minimum duty at the top
      drain(RESULT_LATENCY);
      set_config(cfg_of(0, 0, 4095, 0, 0, 0, 0, 32767));
      random_samples(RANDOM_PER_CFG);

      // plausible setups, then one with raw bits everywhere
      for (int p = 0; p < 4; p++) begin
         drain(RESULT_LATENCY);
         set_config(random_cfg(p == 3));
         random_samples(RANDOM_PER_CFG);
      end

      drain(2 * RESULT_LATENCY);
      if (duty_sb.errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
